FILE: rtl/crp_pkg.sv
// ----------------------------------------------------------------------------
// CSV rating record parser package
// Shared types and character codes for the parser datapath and result stage.
// ----------------------------------------------------------------------------
package crp_pkg;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_DOT     = 8'd46;
  localparam logic [7:0] CHAR_ZERO    = 8'd48;
  localparam logic [7:0] CHAR_NINE    = 8'd57;
  localparam logic [7:0] SEP_RESET    = 8'd44;

  localparam logic [4:0] RINT_MAX   = 5'd31;
  localparam logic [8:0] TENTHS_MAX = 9'd255;

  typedef enum logic [5:0] {
    PH_USER      = 6'b000001,
    PH_MOVIE     = 6'b000010,
    PH_RINT      = 6'b000100,
    PH_FRAC      = 6'b001000,
    PH_SKIP_GOOD = 6'b010000,
    PH_SKIP_BAD  = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0]  rating_tenths;
    logic [31:0] movie_id;
    logic [31:0] user_id;
  } rec_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } emit_t;

endpackage

FILE: rtl/csv_rating_record_parser.sv
// ----------------------------------------------------------------------------
// CSV rating record parser
// Turns a byte stream of "user,movie,rating" lines into binary records.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one text byte per transaction, tlast marks the final byte
//   of a chunk. Master stream: one record per well-formed line, sent on the
//   line's newline or on the tlast byte. Bad lines produce nothing.
//   Config channel: writes the field separator byte (comma after reset);
//   write it only while the block is idle. It is always ready.
// Timing:
//   One byte per clock while no record is held back by the master side. A record
//   appears on the master side in the cycle after the byte that closes its
//   line. Each byte is handled by the combinational accumulator update
//   (shift-and-add times ten) ahead of the one-entry result register.
// Reset:
//   Clears the line state and the result valid flag, restores the comma separator.
// Stall:
//   While the master side holds a record, s_axis_tready_o follows
//   m_axis_tready_i; bytes keep flowing when the receiver takes the record.
// ----------------------------------------------------------------------------
module csv_rating_record_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [31:0] user_id, [63:32] movie_id,
                                        // [71:64] rating_tenths
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  logic [7:0]     sep_q;
  logic           free;
  logic           accept;
  crp_pkg::emit_t emit;
  crp_pkg::rec_t  rec;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = free;
  assign accept          = s_axis_tvalid_i && free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= crp_pkg::SEP_RESET;
    end else if (cfg_valid_i) begin
      sep_q <= cfg_data_i;
    end
  end

  crp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .text_byte_i (s_axis_tdata_i),
    .last_byte_i (s_axis_tlast_i),
    .sep_i       (sep_q),
    .emit_o      (emit)
  );

  crp_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .emit_i    (emit),
    .free_o    (free),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_rec_o   (rec)
  );

  assign m_axis_tdata_o = {rec.rating_tenths, rec.movie_id, rec.user_id};

endmodule

FILE: rtl/crp_parser.sv
// ----------------------------------------------------------------------------
// CSV rating record parser - line state and field accumulators
// Updates the line phase and decimal accumulators on each accepted byte and
// flags a finished record in the same cycle.
// ----------------------------------------------------------------------------
module crp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          text_byte_i,
  input  logic                last_byte_i,
  input  logic [7:0]          sep_i,
  output crp_pkg::emit_t      emit_o
);

  crp_pkg::phase_e phase_q, phase_d, phase_p;
  logic [31:0] user_q, user_d, user_p;
  logic [31:0] movie_q, movie_d, movie_p;
  logic [4:0]  rint_q, rint_d, rint_p;
  logic [3:0]  frac_q, frac_d, frac_p;

  logic        is_digit;
  logic [3:0]  digit;
  logic [8:0]  rint_ext;
  logic        good_cur, good_p;
  crp_pkg::rec_t rec_cur, rec_p;

  assign is_digit = text_byte_i inside {[crp_pkg::CHAR_ZERO:crp_pkg::CHAR_NINE]};
  assign digit    = is_digit ? 4'(text_byte_i - crp_pkg::CHAR_ZERO) : 4'd0;
  // times ten as shift-and-add; 5-bit value times ten fits in 9 bits
  assign rint_ext = {1'b0, rint_q, 3'b000} + {3'b000, rint_q, 1'b0} + {5'd0, digit};

  // Process the byte as a non-newline character
  always_comb begin
    phase_p = phase_q;
    user_p  = user_q;
    movie_p = movie_q;
    rint_p  = rint_q;
    frac_p  = frac_q;
    case (phase_q)
      crp_pkg::PH_USER: begin
        if (is_digit) begin
          user_p = {user_q[28:0], 3'b000} + {user_q[30:0], 1'b0} + {28'd0, digit};
        end else if (text_byte_i == sep_i) begin
          phase_p = crp_pkg::PH_MOVIE;
        end else begin
          phase_p = crp_pkg::PH_SKIP_BAD;
        end
      end
      crp_pkg::PH_MOVIE: begin
        if (is_digit) begin
          movie_p = {movie_q[28:0], 3'b000} + {movie_q[30:0], 1'b0} + {28'd0, digit};
        end else if (text_byte_i == sep_i) begin
          phase_p = crp_pkg::PH_RINT;
        end else begin
          phase_p = crp_pkg::PH_SKIP_BAD;
        end
      end
      crp_pkg::PH_RINT: begin
        if (is_digit) begin
          rint_p = (rint_ext > {4'd0, crp_pkg::RINT_MAX}) ? crp_pkg::RINT_MAX
                                                          : rint_ext[4:0];
        end else if (text_byte_i == crp_pkg::CHAR_DOT) begin
          phase_p = crp_pkg::PH_FRAC;
        end else begin
          phase_p = crp_pkg::PH_SKIP_GOOD;
        end
      end
      crp_pkg::PH_FRAC: begin
        if (is_digit) begin
          frac_p = digit;
        end
        phase_p = crp_pkg::PH_SKIP_GOOD;
      end
      crp_pkg::PH_SKIP_GOOD: begin
        phase_p = crp_pkg::PH_SKIP_GOOD;
      end
      default: begin
        phase_p = crp_pkg::PH_SKIP_BAD;
      end
    endcase
  end

  function automatic crp_pkg::rec_t make_rec(logic [31:0] u, logic [31:0] m,
                                             logic [4:0] ri, logic [3:0] fr);
    crp_pkg::rec_t r;
    logic [8:0]    t;
    t = {1'b0, ri, 3'b000} + {3'b000, ri, 1'b0} + {5'd0, fr};
    r.user_id       = u;
    r.movie_id      = m;
    r.rating_tenths = (t > crp_pkg::TENTHS_MAX) ? 8'hFF : t[7:0];
    return r;
  endfunction

  assign good_cur = (phase_q == crp_pkg::PH_RINT) || (phase_q == crp_pkg::PH_FRAC) ||
                    (phase_q == crp_pkg::PH_SKIP_GOOD);
  assign good_p   = (phase_p == crp_pkg::PH_RINT) || (phase_p == crp_pkg::PH_FRAC) ||
                    (phase_p == crp_pkg::PH_SKIP_GOOD);
  assign rec_cur  = make_rec(user_q, movie_q, rint_q, frac_q);
  assign rec_p    = make_rec(user_p, movie_p, rint_p, frac_p);

  // Newline or last byte closes the line; otherwise advance
  always_comb begin
    emit_o.valid = 1'b0;
    emit_o.rec   = rec_p;
    phase_d      = phase_p;
    user_d       = user_p;
    movie_d      = movie_p;
    rint_d       = rint_p;
    frac_d       = frac_p;
    if (text_byte_i == crp_pkg::CHAR_NEWLINE) begin
      emit_o.valid = accept_i && good_cur;
      emit_o.rec   = rec_cur;
    end else if (last_byte_i) begin
      emit_o.valid = accept_i && good_p;
    end
    if ((text_byte_i == crp_pkg::CHAR_NEWLINE) || last_byte_i) begin
      phase_d = crp_pkg::PH_USER;
      user_d  = '0;
      movie_d = '0;
      rint_d  = '0;
      frac_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= crp_pkg::PH_USER;
      user_q  <= '0;
      movie_q <= '0;
      rint_q  <= '0;
      frac_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      user_q  <= user_d;
      movie_q <= movie_d;
      rint_q  <= rint_d;
      frac_q  <= frac_d;
    end
  end

endmodule

FILE: rtl/crp_out_stage.sv
// ----------------------------------------------------------------------------
// CSV rating record parser - result register
// Holds one finished record until the downstream side takes it.
// ----------------------------------------------------------------------------
module crp_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  crp_pkg::emit_t emit_i,
  output logic           free_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output crp_pkg::rec_t  m_rec_o
);

  logic          valid_q;
  crp_pkg::rec_t rec_q;

  // slot frees up in the same cycle the held transaction leaves
  assign free_o    = !valid_q || m_ready_i;
  assign m_valid_o = valid_q;
  assign m_rec_o   = rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (emit_i.valid) begin
      valid_q <= 1'b1;
    end else if (m_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.valid) begin
      rec_q <= emit_i.rec;
    end
  end

endmodule
